// ----- hdl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: request and response
// words, request codes and status codes.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_READ_FRONT = 3'd4;
    localparam logic [2:0] REQ_READ_BACK  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    // Value returned on an empty pop or read
    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    // One request word
    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] data_in;
    } req_word_t;

    // One response word
    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic               is_empty;
        logic [4:0]         entry_count;
    } rsp_word_t;

endpackage

// ----- hdl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that updates only when a read is issued.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/double_ended_queue.sv -----
// Double-ended queue over a ring of CAPACITY 32-bit entries in one RAM.
// An accepted request passes the second-stage registers, then the output register.
// Throughput: one request per cycle unless rsp_stall backs the block up; the RAM
// takes one access per request and its registered read is the second stage.
// Reset (rst_n, async, active low): queue empty, indices zero, no word in flight.
// RAM contents are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// double_ended_queue
// Push, pop and read at both ends of a ring buffer. Indices and count live in
// registers; the entries live in deq_ram. Each request is decided in the first
// stage, the RAM read returns in the second, then the response is registered.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // Queue control state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Second stage: waiting for the RAM read
    logic              p1_valid_reg;
    logic              p1_use_mem_reg;
    logic [1:0]        p1_status_reg;
    logic              p1_empty_reg;
    logic [4:0]        p1_count_reg;

    // Output register
    logic      rsp_valid_reg;
    rsp_word_t rsp_word_reg;

    // RAM interface
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_data;

    logic advance;
    logic accept;
    logic is_full;
    logic is_empty_now;
    logic [IDX_W-1:0] front_up, front_dn, back_up, back_dn;
    logic [1:0]       status_next;
    logic             use_mem_next;
    logic [CNT_W+4:0] count_ext;

    // Handshake: second stage moves on whenever the output slot frees up
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = p1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    // Ring index arithmetic
    assign front_up = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);
    assign front_dn = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign back_up  = (back_reg == LAST_IDX) ? '0 : back_reg + IDX_W'(1);
    assign back_dn  = (back_reg == '0) ? LAST_IDX : back_reg - IDX_W'(1);

    assign is_full      = (count_reg == FULL_CNT);
    assign is_empty_now = (count_reg == '0);

    // Request decode
    always_comb
    begin
        front_next   = front_reg;
        back_next    = back_reg;
        count_next   = count_reg;
        status_next  = ST_OK;
        use_mem_next = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = back_reg;
        rd_en        = 1'b0;
        rd_addr      = front_reg;
        if (accept)
        begin
            case (req_word.req_type)
                REQ_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_OVER;
                    end
                    else
                    begin
                        front_next = front_dn;
                        wr_en      = 1'b1;
                        wr_addr    = front_dn;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_OVER;
                    end
                    else
                    begin
                        back_next  = back_up;
                        wr_en      = 1'b1;
                        wr_addr    = back_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK, REQ_READ_FRONT, REQ_READ_BACK:
                begin
                    if (is_empty_now)
                    begin
                        status_next = ST_UNDER;
                    end
                    else
                    begin
                        use_mem_next = 1'b1;
                        rd_en        = 1'b1;
                        case (req_word.req_type)
                            REQ_POP_FRONT:
                            begin
                                rd_addr    = front_reg;
                                front_next = front_up;
                                count_next = count_reg - CNT_W'(1);
                            end
                            REQ_POP_BACK:
                            begin
                                rd_addr    = back_dn;
                                back_next  = back_dn;
                                count_next = count_reg - CNT_W'(1);
                            end
                            REQ_READ_FRONT:
                            begin
                                rd_addr = front_reg;
                            end
                            default:
                            begin
                                rd_addr = back_dn;
                            end
                        endcase
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    assign count_ext = {5'b0, count_next};

    // Control state and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= p1_valid_reg;
            end
        end
    end

    // Second-stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_use_mem_reg <= use_mem_next;
            p1_status_reg  <= status_next;
            p1_empty_reg   <= (count_next == '0);
            p1_count_reg   <= count_ext[4:0];
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (advance && p1_valid_reg)
        begin
            rsp_word_reg.status      <= p1_status_reg;
            rsp_word_reg.is_empty    <= p1_empty_reg;
            rsp_word_reg.entry_count <= p1_count_reg;
            if (p1_use_mem_reg)
            begin
                rsp_word_reg.data_out <= rd_data;
            end
            else if (p1_status_reg == ST_UNDER)
            begin
                rsp_word_reg.data_out <= EMPTY_VALUE;
            end
            else
            begin
                rsp_word_reg.data_out <= '0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // Entry storage
    deq_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (32),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req_word.data_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ----- hdl/deq_checker.sv -----
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
    import deq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input req_word_t req_word,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_word_t rsp_word
);

    // A stalled request word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_word))
    else $error("request word changed while stalled");

    // A stalled response word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("response word changed while stalled");

    // Empty flag implies a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.is_empty |-> rsp_word.entry_count == 5'd0)
    else $error("empty flag with nonzero count");

    // Underflow returns all ones and an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == ST_UNDER
            |-> rsp_word.data_out == EMPTY_VALUE && rsp_word.is_empty)
    else $error("bad underflow response");

    // Overflow returns zero and a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == ST_OVER
            |-> rsp_word.data_out == '0 && !rsp_word.is_empty)
    else $error("bad overflow response");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);

// ----- tb/double_ended_queue_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the double-ended queue. Requests are pushed from
// both ends, popped and read, against an empty and a full queue. A software
// copy of the ring predicts every response word, and a monitor compares each
// accepted word field by field. Both sides idle in random bursts. Once the
// receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int ITEM_TARGET  = 1550;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_LIMIT  = 40;

    // Codes the block must treat as no-ops
    localparam logic [2:0] REQ_UNDEF_6 = 3'd6;
    localparam logic [2:0] REQ_UNDEF_7 = 3'd7;

    // Shapes of a random phase
    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req_word  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;

    // Words waiting to be offered, and responses predicted but not yet seen
    req_word_t pending_reqs[$];
    rsp_word_t expected_rsps[$];

    // Software copy of the queue
    logic signed [31:0] mdl_ring [CAPACITY];
    int mdl_front = 0;
    int mdl_back  = 0;
    int mdl_count = 0;

    // Knobs written by the stimulus process
    logic send_idle_en    = 1'b0;
    logic recv_idle_en    = 1'b0;
    int   long_hold_asked = 0;

    int send_gap         = 0;
    int stall_left       = 0;
    int long_hold_served = 0;
    int items_queued     = 0;
    int words_seen       = 0;
    int mismatch_count   = 0;
    int cycle_count      = 0;
    int n_push           = 0;
    int n_pop            = 0;
    int n_read           = 0;
    int n_overflow       = 0;
    int n_underflow      = 0;
    int n_undef          = 0;
    int peak_count       = 0;

    double_ended_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word (req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word (rsp_word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int ring_next(int idx);
        return (idx + 1) % CAPACITY;
    endfunction

    function automatic int ring_prev(int idx);
        return (idx + CAPACITY - 1) % CAPACITY;
    endfunction

    // Apply one accepted request to the copy and queue the response it gives
    function automatic void deque_apply_request(req_word_t w);
        rsp_word_t r;
        r.data_out = '0;
        r.status   = ST_OK;
        case (w.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                n_push++;
                if (mdl_count >= CAPACITY)
                begin
                    r.status = ST_OVER;
                    n_overflow++;
                end
                else if (w.req_type == REQ_PUSH_FRONT)
                begin
                    mdl_front = ring_prev(mdl_front);
                    mdl_ring[mdl_front] = w.data_in;
                    mdl_count++;
                end
                else
                begin
                    mdl_ring[mdl_back] = w.data_in;
                    mdl_back = ring_next(mdl_back);
                    mdl_count++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK, REQ_READ_FRONT, REQ_READ_BACK:
            begin
                if (w.req_type == REQ_POP_FRONT || w.req_type == REQ_POP_BACK)
                    n_pop++;
                else
                    n_read++;
                if (mdl_count == 0)
                begin
                    r.data_out = EMPTY_VALUE;
                    r.status   = ST_UNDER;
                    n_underflow++;
                end
                else if (w.req_type == REQ_POP_FRONT)
                begin
                    r.data_out = mdl_ring[mdl_front];
                    mdl_front = ring_next(mdl_front);
                    mdl_count--;
                end
                else if (w.req_type == REQ_POP_BACK)
                begin
                    mdl_back = ring_prev(mdl_back);
                    r.data_out = mdl_ring[mdl_back];
                    mdl_count--;
                end
                else if (w.req_type == REQ_READ_FRONT)
                    r.data_out = mdl_ring[mdl_front];
                else
                    r.data_out = mdl_ring[ring_prev(mdl_back)];
            end
            default:
                n_undef++;
        endcase
        if (mdl_count > peak_count)
            peak_count = mdl_count;
        r.is_empty    = (mdl_count == 0);
        r.entry_count = 5'(mdl_count);
        expected_rsps = {expected_rsps, r};
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: expected %h, got %h", $time, field, want, got);
    endtask

    // Random values half the time, else one of the extremes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_req(logic [2:0] code, logic [31:0] value);
        req_word_t w;
        w.req_type   = code;
        w.data_in    = value;
        pending_reqs = {pending_reqs, w};
        items_queued++;
    endtask

    // One random phase: pushes to fill, pops to drain past empty, or a mix
    task automatic add_phase(int shape);
        int n;
        logic [2:0] code;
        n = (shape == PH_MIXED) ? $urandom_range(10, 40) : $urandom_range(18, 26);
        repeat (n)
        begin
            if (shape == PH_FILL)
                code = ($urandom_range(0, 3) != 0)
                     ? 3'($urandom_range(REQ_PUSH_FRONT, REQ_PUSH_BACK))
                     : 3'($urandom_range(REQ_READ_FRONT, REQ_READ_BACK));
            else if (shape == PH_DRAIN)
                code = ($urandom_range(0, 3) != 0)
                     ? 3'($urandom_range(REQ_POP_FRONT, REQ_POP_BACK))
                     : 3'($urandom_range(REQ_READ_FRONT, REQ_READ_BACK));
            else if ($urandom_range(0, 19) == 0)
                code = $urandom_range(0, 1) ? REQ_UNDEF_7 : REQ_UNDEF_6;
            else
                code = 3'($urandom_range(REQ_PUSH_FRONT, REQ_READ_BACK));
            queue_req(code, pick_value());
        end
    endtask

    task automatic wait_all_answered();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        req_word_t nxt_word;
        logic      nxt_valid;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word  <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                deque_apply_request(req_word);
            // a held word stays put until taken
            if (!req_valid || !req_stall)
            begin
                nxt_valid = 1'b0;
                nxt_word  = req_word;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (send_idle_en && $urandom_range(0, 11) == 0)
                    send_gap <= $urandom_range(0, 18);
                else if (pending_reqs.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_word  = pending_reqs[0];
                    pending_reqs.delete(0);
                end
                req_valid <= nxt_valid;
                req_word  <= nxt_word;
            end
        end
    end

    // Response monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_word_t want;
        if (!rst_n)
        begin
            rsp_stall        <= 1'b0;
            stall_left       <= 0;
            long_hold_served <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                words_seen++;
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected word", '0, rsp_word.data_out);
                else
                begin
                    want = expected_rsps[0];
                    expected_rsps.delete(0);
                    if (rsp_word.data_out !== want.data_out)
                        report_mismatch("data_out", want.data_out, rsp_word.data_out);
                    if (rsp_word.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(rsp_word.status));
                    if (rsp_word.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(want.is_empty),
                                        32'(rsp_word.is_empty));
                    if (rsp_word.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(want.entry_count),
                                        32'(rsp_word.entry_count));
                end
            end
            // long hold when asked, else random stall bursts
            if (long_hold_served != long_hold_asked)
            begin
                long_hold_served <= long_hold_asked;
                stall_left       <= LONG_HOLD - 1;
                rsp_stall        <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_stall  <= 1'b1;
            end
            else if (recv_idle_en && $urandom_range(0, 11) == 0)
            begin
                stall_left <= $urandom_range(0, 18);
                rsp_stall  <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty queue, both extremes at both ends, wrap of the indices
        queue_req(REQ_READ_FRONT, $urandom);
        queue_req(REQ_READ_BACK, $urandom);
        queue_req(REQ_POP_FRONT, $urandom);
        queue_req(REQ_POP_BACK, $urandom);
        queue_req(REQ_UNDEF_6, $urandom);
        queue_req(REQ_UNDEF_7, $urandom);
        queue_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        queue_req(REQ_PUSH_BACK, 32'h8000_0000);
        queue_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_req(REQ_PUSH_BACK, 32'h0000_0000);
        queue_req(REQ_READ_FRONT, $urandom);
        queue_req(REQ_READ_BACK, $urandom);
        queue_req(REQ_UNDEF_6, $urandom);
        queue_req(REQ_POP_FRONT, $urandom);
        queue_req(REQ_POP_BACK, $urandom);
        queue_req(REQ_POP_BACK, $urandom);
        queue_req(REQ_POP_FRONT, $urandom);
        queue_req(REQ_POP_BACK, $urandom);
        queue_req(REQ_PUSH_BACK, 32'h5A5A_A5A5);
        queue_req(REQ_READ_FRONT, $urandom);
        queue_req(REQ_POP_FRONT, $urandom);
        wait_all_answered();

        // Back-pressure: receiver holds while the sender keeps offering
        add_phase(PH_FILL);
        add_phase(PH_DRAIN);
        add_phase(PH_MIXED);
        long_hold_asked++;
        wait_all_answered();

        // Random phases with idling switched per phase
        while (items_queued < ITEM_TARGET - QUIET_TAIL)
        begin
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
            add_phase($urandom_range(PH_FILL, PH_MIXED));
            while (pending_reqs.size() != 0)
                @(negedge clk);
            if ($urandom_range(0, 4) == 0)
                wait_all_answered();
        end

        // Tail at full rate
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        while (items_queued < ITEM_TARGET)
            add_phase($urandom_range(PH_FILL, PH_MIXED));
        wait_all_answered();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_rsps.size() != 0)
            report_mismatch("missing words", expected_rsps.size(), '0);

        $display("Ran %0d requests, %0d response words: %0d pushes, %0d pops,",
                 items_queued, words_seen, n_push, n_pop);
        $display("%0d reads, %0d no-ops; overflows %0d, underflows %0d, deepest fill %0d of %0d",
                 n_read, n_undef, n_overflow, n_underflow, peak_count, CAPACITY);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/double_ended_queue.sv
hdl/deq_checker.sv
tb/double_ended_queue_tb.sv
